// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files that check themselves.
// Each check is sampled on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every checked edge.
`define RBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a checked edge.
`define RBR_NEVER(lbl, cond, msg) \
  `RBR_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/rbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_pkg
// Shared types, constants and helpers of the bilinear RGB resizer.
// ----------------------------------------------------------------------------
package rbr_pkg;

  // Field widths of the configuration registers.
  localparam int unsigned SW_W       = 9;
  localparam int unsigned TW_W       = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Fixed-point datapath widths.
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned ACC_W    = 26;
  localparam int unsigned STEP_W   = 25;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned WGT_W    = 17;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned CHANNELS = 3;
  localparam int unsigned HALF_STEP  = 32768;
  localparam int unsigned WGT_ONE    = 256;
  localparam int unsigned MAX_TARGET = 1024;

  // Divider operands: source size shifted by the fraction, target size.
  localparam int unsigned DIVIDEND_W = SW_W + FRAC_W;
  localparam int unsigned DIVISOR_W  = TW_W;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int unsigned DEF_MAX_SOURCE_HEIGHT = 256;

  // Reset values of the size registers.
  localparam logic [SW_W-1:0] RST_SRC = 9'd256;
  localparam logic [TW_W-1:0] RST_TGT = 11'd256;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_TGT_W = 2'd2,
    REG_TGT_H = 2'd3
  } cfg_reg_e;

  // Item kinds carried in tuser.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic [SW_W-1:0] src_w;
    logic [SW_W-1:0] src_h;
    logic [TW_W-1:0] tgt_w;
    logic [TW_W-1:0] tgt_h;
  } cfg_t;

  // One classified input item as it waits in the queue.
  typedef struct packed {
    logic              action;
    logic              load_ok;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [PIX_W-1:0]  pix;
  } item_t;

  typedef struct packed {
    logic busy;
    logic out_fire;
  } status_t;

  // Source size saturated to 2..hi.
  function automatic logic [SW_W-1:0] clamp_src(logic [SW_W-1:0] v, int unsigned hi);
    logic [SW_W-1:0] r;
    r = v;
    if (v < SW_W'(2)) r = SW_W'(2);
    else if (32'(v) > hi) r = SW_W'(hi);
    return r;
  endfunction

  // Target size saturated to 1..MAX_TARGET.
  function automatic logic [TW_W-1:0] clamp_tgt(logic [TW_W-1:0] v);
    logic [TW_W-1:0] r;
    r = v;
    if (v < TW_W'(1)) r = TW_W'(1);
    else if (v > TW_W'(MAX_TARGET)) r = TW_W'(MAX_TARGET);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rbr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module rbr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // One access per cycle: write or read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/rbr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_fifo
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rbr_fifo #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]           mem_q [DEPTH];
  logic [PW-1:0]              wp_q, wp_d, rp_q, rp_d;
  logic [$clog2(DEPTH+1)-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == ($clog2(DEPTH+1))'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rp_q];

  // Pointer and fill count update.
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + ($clog2(DEPTH+1))'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - ($clog2(DEPTH+1))'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rbr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_div
// Restoring divider, one quotient bit per cycle, for the per-frame steps.
// ----------------------------------------------------------------------------
module rbr_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [rbr_pkg::DIVIDEND_W-1:0]      dividend_i,
  input  wire logic [rbr_pkg::DIVISOR_W-1:0]       divisor_i,
  output logic                                     done_o,
  output logic      [rbr_pkg::DIVIDEND_W-1:0]      quotient_o
);
  import rbr_pkg::*;

  localparam int unsigned IW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d, done_q, done_d;
  logic [IW-1:0]         cnt_q, cnt_d;
  logic [DIVISOR_W:0]    rem_q, rem_d, rem_sh;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  den_q, den_d;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // One shift-subtract step per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + IW'(1);
      if (cnt_q == IW'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

// ----- rtl/rbr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_core
// Back end: frame store writes, step division, neighbour fetch and blend.
// ----------------------------------------------------------------------------
module rbr_core #(
  parameter int unsigned MAX_SOURCE_WIDTH  = rbr_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int unsigned MAX_SOURCE_HEIGHT = rbr_pkg::DEF_MAX_SOURCE_HEIGHT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rbr_pkg::cfg_t                 cfg_i,
  input  wire logic                          item_valid_i,
  input  wire rbr_pkg::item_t                item_i,
  output logic                               item_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rbr_pkg::PIX_W-1:0]          out_data_o,
  output logic                               out_last_o,
  output rbr_pkg::status_t                   status_o
);
  import rbr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned RW = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned AW = CW + RW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIVX = 7'b0000010,
    S_DIVY = 7'b0000100,
    S_POS  = 7'b0001000,
    S_WGT  = 7'b0010000,
    S_MAC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SW_W-1:0]          lat_sw_q, lat_sw_d, lat_sh_q, lat_sh_d;
  logic [TW_W-1:0]          lat_tw_q, lat_tw_d, lat_th_q, lat_th_d;
  logic [STEP_W-1:0]        xstep_q, xstep_d, ystep_q, ystep_d;
  logic signed [ACC_W-1:0]  xacc_q, xacc_d, yacc_q, yacc_d;
  logic [CNT_W-1:0]         col_q, col_d, row_q, row_d;
  logic [CHAN_W-1:0]        u_q, u_d, v_q, v_d;
  logic [SW_W-1:0]          kp_q, kp_d, kq_q, kq_d;
  logic [WGT_W-1:0]         w_q [4];
  logic [WGT_W-1:0]         w_d [4];
  logic [2:0]               cnt_q, cnt_d;
  logic [PIX_W-1:0]         sum_q [CHANNELS];
  logic [PIX_W-1:0]         sum_d [CHANNELS];
  logic                     ov_q, ov_d, olast_q, olast_d;
  logic [PIX_W-1:0]         odata_q, odata_d;

  logic                     div_start, div_done;
  logic [DIVIDEND_W-1:0]    div_num, div_q;
  logic [DIVISOR_W-1:0]     div_den;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [PIX_W-1:0]         ram_rd;
  logic [STEP_W-1:0]        ystep_new;
  logic [SW_W-1:0]          c_sw, c_sh;
  logic [TW_W-1:0]          c_tw, c_th;
  logic [CHAN_W:0]          nu, nv;
  logic [1:0]               wi;
  logic [TW_W-1:0]          col_nx, row_nx;
  logic [SW_W-1:0]          rd_col, rd_row;
  logic                     commit;

  // Half-step start offset of an accumulator.
  function automatic logic signed [ACC_W-1:0] start_ofs(logic [STEP_W-1:0] step);
    return $signed(ACC_W'(step >> 1)) - $signed(ACC_W'(HALF_STEP));
  endfunction

  // Integer part of a position, negative values to zero, clamped to lim.
  function automatic logic [SW_W-1:0] int_part(logic signed [ACC_W-1:0] a,
                                               logic [SW_W-1:0] lim);
    logic [SW_W-1:0] p;
    p = a[FRAC_W+SW_W-1:FRAC_W];
    if (a[ACC_W-1]) p = '0;
    else if (p > lim) p = lim;
    return p;
  endfunction

  function automatic logic [AW-1:0] store_addr(logic [SW_W-1:0] r, logic [SW_W-1:0] c);
    return AW'((32'(r) << CW) | 32'(c));
  endfunction

  rbr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  rbr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (item_i.pix),
    .rdata_o (ram_rd)
  );

  assign c_sw = clamp_src(cfg_i.src_w, MAX_SOURCE_WIDTH);
  assign c_sh = clamp_src(cfg_i.src_h, MAX_SOURCE_HEIGHT);
  assign c_tw = clamp_tgt(cfg_i.tgt_w);
  assign c_th = clamp_tgt(cfg_i.tgt_h);

  assign nu        = (CHAN_W + 1)'(WGT_ONE) - {1'b0, u_q};
  assign nv        = (CHAN_W + 1)'(WGT_ONE) - {1'b0, v_q};
  assign wi        = 2'(cnt_q - 3'd1);
  assign ystep_new = div_q + STEP_W'(1);
  assign col_nx    = TW_W'(col_q) + TW_W'(1);
  assign row_nx    = TW_W'(row_q) + TW_W'(1);
  assign commit    = (state_q == S_OUT) && (!ov_q || out_ready_i);

  // Neighbour order: top-left, bottom-left, top-right, bottom-right.
  assign rd_col = kp_q + SW_W'(cnt_q[1]);
  assign rd_row = kq_q + SW_W'(cnt_q[0]);

  assign out_valid_o       = ov_q;
  assign out_data_o        = odata_q;
  assign out_last_o        = olast_q;
  assign status_o.busy     = (state_q != S_IDLE);
  assign status_o.out_fire = commit;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    lat_sw_d = lat_sw_q;
    lat_sh_d = lat_sh_q;
    lat_tw_d = lat_tw_q;
    lat_th_d = lat_th_q;
    xstep_d  = xstep_q;
    ystep_d  = ystep_q;
    xacc_d   = xacc_q;
    yacc_d   = yacc_q;
    col_d    = col_q;
    row_d    = row_q;
    u_d      = u_q;
    v_d      = v_q;
    kp_d     = kp_q;
    kq_d     = kq_q;
    w_d      = w_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    ov_d     = ov_q && !out_ready_i;
    olast_d  = olast_q;
    odata_d  = odata_q;
    item_pop_o = 1'b0;
    div_start  = 1'b0;
    div_num    = {c_sw, FRAC_W'(0)};
    div_den    = c_tw;
    ram_we     = 1'b0;
    ram_addr   = store_addr(rd_row, rd_col);
    unique case (state_q)
      S_IDLE: begin
        ram_addr = store_addr(SW_W'(item_i.row), SW_W'(item_i.col));
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.action == ACT_LOAD) begin
            ram_we = item_i.load_ok;
          end else if (col_q == '0 && row_q == '0) begin
            // Frame start: latch sizes, work out the x step.
            lat_sw_d  = c_sw;
            lat_sh_d  = c_sh;
            lat_tw_d  = c_tw;
            lat_th_d  = c_th;
            div_start = 1'b1;
            state_d   = S_DIVX;
          end else begin
            state_d = S_POS;
          end
        end
      end
      S_DIVX: begin
        div_num = {lat_sh_q, FRAC_W'(0)};
        div_den = lat_th_q;
        if (div_done) begin
          xstep_d   = div_q + STEP_W'(1);
          xacc_d    = start_ofs(div_q + STEP_W'(1));
          div_start = 1'b1;
          state_d   = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          ystep_d = ystep_new;
          yacc_d  = start_ofs(ystep_new);
          state_d = S_POS;
        end
      end
      S_POS: begin
        u_d     = xacc_q[FRAC_W-1:FRAC_W-CHAN_W];
        v_d     = yacc_q[FRAC_W-1:FRAC_W-CHAN_W];
        kp_d    = int_part(xacc_q, lat_sw_q - SW_W'(2));
        kq_d    = int_part(yacc_q, lat_sh_q - SW_W'(2));
        state_d = S_WGT;
      end
      S_WGT: begin
        w_d[0] = WGT_W'(nu * nv);
        w_d[1] = WGT_W'({1'b0, v_q} * nu);
        w_d[2] = WGT_W'({1'b0, u_q} * nv);
        w_d[3] = WGT_W'({1'b0, u_q} * {1'b0, v_q});
        for (int k = 0; k < CHANNELS; k++) begin
          sum_d[k] = '0;
        end
        cnt_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        // Read one neighbour, blend the one read in the previous cycle.
        if (cnt_q != 3'd0) begin
          for (int k = 0; k < CHANNELS; k++) begin
            sum_d[k] = sum_q[k] + PIX_W'(w_q[wi] * ram_rd[k*CHAN_W +: CHAN_W]);
          end
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (commit) begin
          ov_d    = 1'b1;
          olast_d = 1'b0;
          for (int k = 0; k < CHANNELS; k++) begin
            odata_d[k*CHAN_W +: CHAN_W] = sum_q[k][PIX_W-1:FRAC_W];
          end
          // Advance in raster order.
          if (col_nx >= lat_tw_q) begin
            col_d  = '0;
            xacc_d = start_ofs(xstep_q);
            yacc_d = yacc_q + $signed(ACC_W'(ystep_q));
            if (row_nx >= lat_th_q) begin
              row_d   = '0;
              olast_d = 1'b1;
            end else begin
              row_d = CNT_W'(row_nx);
            end
          end else begin
            col_d  = CNT_W'(col_nx);
            xacc_d = xacc_q + $signed(ACC_W'(xstep_q));
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    lat_sw_q <= lat_sw_d;
    lat_sh_q <= lat_sh_d;
    lat_tw_q <= lat_tw_d;
    lat_th_q <= lat_th_d;
    xstep_q  <= xstep_d;
    ystep_q  <= ystep_d;
    xacc_q   <= xacc_d;
    yacc_q   <= yacc_d;
    u_q      <= u_d;
    v_q      <= v_d;
    kp_q     <= kp_d;
    kq_q     <= kq_d;
    w_q      <= w_d;
    cnt_q    <= cnt_d;
    sum_q    <= sum_d;
    olast_q  <= olast_d;
    odata_q  <= odata_d;
  end
endmodule
`default_nettype wire

// ----- rtl/bilinear_resize_rgb_fixed.sv -----
// Load transfer: queued, then written to the store when it is at the queue head and the back
// end is idle. Request transfer: from queue head to result via position, weights, four
// single-port store reads blended one per cycle, and the output register. Throughput: one
// load per cycle while the back end is idle; no new item is taken until the previous result
// is in the output register. The first request of a frame also runs the two step divisions.
// Reset (asynchronous, rst_ni low) clears the counters, queue and output; store is undefined.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_resize_rgb_fixed
// Bilinear RGB resizer: load source pixels, then stream destination pixels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bilinear_resize_rgb_fixed #(
  parameter int unsigned MAX_SOURCE_WIDTH  = rbr_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int unsigned MAX_SOURCE_HEIGHT = rbr_pkg::DEF_MAX_SOURCE_HEIGHT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rbr_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [rbr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // load_column, load_row, in_chan0, in_chan1, in_chan2
  input  wire logic [39:0]                       s_axis_tdata,
  // action
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_chan0, out_chan1, out_chan2
  output logic [23:0]                            m_axis_tdata,
  // frame_last
  output logic                                   m_axis_tlast
);
  import rbr_pkg::*;

  localparam int unsigned QW = $bits(item_t);

  cfg_t                             cfg_q;
  item_t                            in_item, head_item;
  logic                             push, pop, full, empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] fill;
  logic [QW-1:0]                    head_raw;
  status_t                          st;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= RST_SRC;
      cfg_q.src_h <= RST_SRC;
      cfg_q.tgt_w <= RST_TGT;
      cfg_q.tgt_h <= RST_TGT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_SRC_W: cfg_q.src_w <= cfg_data_i[SW_W-1:0];
        REG_SRC_H: cfg_q.src_h <= cfg_data_i[SW_W-1:0];
        REG_TGT_W: cfg_q.tgt_w <= cfg_data_i;
        REG_TGT_H: cfg_q.tgt_h <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: classify each transfer and queue it.
  always_comb begin
    in_item.action  = s_axis_tuser;
    in_item.col     = s_axis_tdata[7:0];
    in_item.row     = s_axis_tdata[15:8];
    in_item.pix     = s_axis_tdata[39:16];
    in_item.load_ok = (32'(s_axis_tdata[7:0]) < MAX_SOURCE_WIDTH) &&
                      (32'(s_axis_tdata[15:8]) < MAX_SOURCE_HEIGHT);
  end

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;
  assign head_item     = item_t'(head_raw);

  rbr_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (QW'(in_item)),
    .pop_i   (pop),
    .rdata_o (head_raw),
    .full_o  (full),
    .empty_o (empty),
    .count_o (fill)
  );

  // Back end.
  rbr_core #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!empty),
    .item_i       (head_item),
    .item_pop_o   (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .status_o     (st)
  );

  // Checks.
  `RBR_ASSERT(a_fill_bound, fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue overfilled")
  `RBR_NEVER(a_pop_empty, pop && empty, "pop from empty queue")
  `RBR_ASSERT(a_out_source, $rose(m_axis_tvalid) |-> $past(st.out_fire), "result without blend")
  `RBR_NEVER(a_pop_busy, pop && st.busy, "new item taken while busy")
endmodule
`default_nettype wire
